>>> design/lcdi_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the character LCD byte stream converter.
package lcdi_pkg;

  // Display geometry.
  localparam int unsigned COLUMNS = 16;
  localparam logic [5:0] COL_LIMIT = 6'(COLUMNS);

  // Input function codes.
  localparam logic [2:0] FUNC_CHAR       = 3'd0;
  localparam logic [2:0] FUNC_CLEAR      = 3'd1;
  localparam logic [2:0] FUNC_HOME       = 3'd2;
  localparam logic [2:0] FUNC_SET_CURSOR = 3'd3;
  localparam logic [2:0] FUNC_BACKLIGHT  = 3'd4;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_RANGE   = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  // LCD commands and special characters.
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CH_BACKSPACE  = 8'h08;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_FORMFEED   = 8'h0C;
  localparam logic [7:0] CH_RETURN     = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_PRINT_MAX  = 8'h7F;

  // Low nibble of every bus byte: backlight, enable, read/write, register select.
  localparam logic [3:0] BL_BIT = 4'h8;
  localparam logic [3:0] EN_BIT = 4'h4;
  localparam logic [3:0] RS_BIT = 4'h1;

  // Queue geometry.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One classified input: up to three LCD bytes, or a status-only result.
  typedef struct packed {
    logic [1:0]      nbytes;   // 0 for status-only, else 1 or 3
    logic [2:0][7:0] bytes;
    logic [2:0]      rs;       // register select per LCD byte
    logic            bl;
    logic [1:0]      status;
  } lcd_op_t;

endpackage

>>> design/text_to_char_lcd_i2c_bytes.sv
`timescale 1ns / 1ps
// Top level of the text to character LCD bus byte converter.
// Input transactions carry a character or a command for a two-line character LCD run in
// 4-bit mode behind an I2C port expander; every LCD byte comes out as six expander bytes
// (each nibble plain, with enable, plain again) with the backlight bit ORed in, and an
// input that produces no bus byte gives one status-only result. Output transactions
// leave at one per cycle from the output register while the downstream side accepts
// them; a printable character or a command gives six of them, a backspace eighteen and
// a status-only input one, as the back end's expansion counters step through each byte.
// The front end takes one input per cycle while its two-entry queue has room, so it
// keeps working while the back end or the downstream side stalls.
module text_to_char_lcd_i2c_bytes import lcdi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], column[13:8], line[15:14],
                                 // backlight_req[16], zero[23:17]
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // bus_byte[7:0], status[9:8], zero[15:10]
  output logic        m_tuser,   // byte_valid[0]
  output logic        m_tlast
);

  lcd_op_t    wr_op;
  lcd_op_t    head;
  logic       push;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  logic [7:0] bus_byte;
  logic [1:0] status;

  lcdi_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .func          (s_tuser),
    .char_code     (s_tdata[7:0]),
    .column        (s_tdata[13:8]),
    .line          (s_tdata[15:14]),
    .backlight_req (s_tdata[16]),
    .push          (push),
    .op            (wr_op),
    .q_full        (q_full)
  );

  lcdi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_op      (wr_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lcdi_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .bus_byte   (bus_byte),
    .byte_valid (m_tuser),
    .status     (status),
    .last       (m_tlast)
  );

  assign m_tdata = {6'd0, status, bus_byte};

endmodule

>>> design/lcdi_front.sv
`timescale 1ns / 1ps
// Front end: tracks the cursor and backlight and classifies each input into LCD bytes.
module lcdi_front import lcdi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  char_code,
  input  logic [5:0]  column,
  input  logic [1:0]  line,
  input  logic        backlight_req,
  output logic        push,
  output lcd_op_t     op,
  input  logic        q_full
);

  logic [5:0] cursor_column, cursor_column_next;
  logic       cursor_line, cursor_line_next;
  logic       backlight_flag, backlight_flag_next;
  logic [5:0] col_inc;
  logic [5:0] col_dec;
  logic [7:0] cur_addr_cmd;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign col_inc  = cursor_column + 6'd1;
  assign col_dec  = cursor_column - 6'd1;

  // The second row starts at address 0x40 and a column never reaches 64,
  // so the address is just the row bit above the column.
  assign cur_addr_cmd = CMD_SET_DDRAM | {1'b0, cursor_line, col_dec};

  always_comb begin
    op                  = '0;
    op.bl               = backlight_flag;
    op.status           = STATUS_OK;
    cursor_column_next  = cursor_column;
    cursor_line_next    = cursor_line;
    backlight_flag_next = backlight_flag;
    case (func)
      FUNC_CHAR: begin
        case (char_code)
          CH_NEWLINE: begin
            op.nbytes          = 2'd1;
            op.bytes[0]        = CMD_SET_DDRAM | {1'b0, !cursor_line, 6'd0};
            cursor_column_next = '0;
            cursor_line_next   = !cursor_line;
          end
          CH_RETURN: begin
            op.nbytes          = 2'd1;
            op.bytes[0]        = CMD_SET_DDRAM | {1'b0, cursor_line, 6'd0};
            cursor_column_next = '0;
          end
          CH_FORMFEED: begin
            op.nbytes          = 2'd1;
            op.bytes[0]        = CMD_CLEAR;
            cursor_column_next = '0;
            cursor_line_next   = 1'b0;
          end
          CH_BACKSPACE: begin
            // Step back, overwrite with a space, step back again.
            if (cursor_column != 6'd0) begin
              op.nbytes          = 2'd3;
              op.bytes[0]        = cur_addr_cmd;
              op.bytes[1]        = CH_SPACE;
              op.bytes[2]        = cur_addr_cmd;
              op.rs              = 3'b010;
              cursor_column_next = col_dec;
            end
          end
          default: begin
            if (char_code >= CH_SPACE && char_code <= CH_PRINT_MAX) begin
              op.nbytes = 2'd1;
              op.bytes[0] = char_code;
              op.rs     = 3'b001;
              if (col_inc >= COL_LIMIT) begin
                cursor_column_next = '0;
                cursor_line_next   = !cursor_line;
              end else begin
                cursor_column_next = col_inc;
              end
            end
          end
        endcase
      end
      FUNC_CLEAR: begin
        op.nbytes          = 2'd1;
        op.bytes[0]        = CMD_CLEAR;
        cursor_column_next = '0;
        cursor_line_next   = 1'b0;
      end
      FUNC_HOME: begin
        op.nbytes          = 2'd1;
        op.bytes[0]        = CMD_HOME;
        cursor_column_next = '0;
        cursor_line_next   = 1'b0;
      end
      FUNC_SET_CURSOR: begin
        if (column >= COL_LIMIT || line[1]) begin
          op.status = STATUS_RANGE;
        end else begin
          op.nbytes          = 2'd1;
          op.bytes[0]        = CMD_SET_DDRAM | {1'b0, line[0], column};
          cursor_column_next = column;
          cursor_line_next   = line[0];
        end
      end
      FUNC_BACKLIGHT: begin
        backlight_flag_next = backlight_req;
      end
      default: begin
        op.status = STATUS_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column  <= '0;
      cursor_line    <= 1'b0;
      backlight_flag <= 1'b1;
    end else if (push) begin
      cursor_column  <= cursor_column_next;
      cursor_line    <= cursor_line_next;
      backlight_flag <= backlight_flag_next;
    end
  end

`ifndef SYNTHESIS
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    cursor_column < COL_LIMIT)
    else $error("cursor column left the display width");
`endif

endmodule

>>> design/lcdi_queue.sv
`timescale 1ns / 1ps
// Short show-ahead queue of classified operations between front and back end.
module lcdi_queue import lcdi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  lcd_op_t wr_op,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output lcd_op_t head
);

  lcd_op_t                 entries [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       count;
  logic                    do_push;
  logic                    do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> design/lcdi_back.sv
`timescale 1ns / 1ps
// Back end: expands each queued LCD byte into six expander bus bytes behind an output register.
module lcdi_back import lcdi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  lcd_op_t    head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] bus_byte,
  output logic       byte_valid,
  output logic [1:0] status,
  output logic       last
);

  logic [1:0] byte_idx;
  logic       nib;
  logic [1:0] phase;
  logic       advance;
  logic       last_res;
  logic [7:0] cur_byte;
  logic [3:0] cur_nibble;
  logic [7:0] bus_next;

  assign advance    = head_valid && (!out_valid || out_ready);
  assign cur_byte   = head.bytes[byte_idx];
  assign cur_nibble = nib ? cur_byte[3:0] : cur_byte[7:4];
  assign last_res   = (head.nbytes == 2'd0) ||
                      (byte_idx == head.nbytes - 2'd1 && nib && phase == 2'd2);
  assign pop        = advance && last_res;

  // Enable is raised only in the middle byte of each nibble; read/write stays low.
  always_comb begin
    bus_next = {cur_nibble, 4'h0};
    if (head.bl) begin
      bus_next[3:0] = bus_next[3:0] | BL_BIT;
    end
    if (phase == 2'd1) begin
      bus_next[3:0] = bus_next[3:0] | EN_BIT;
    end
    if (head.rs[byte_idx]) begin
      bus_next[3:0] = bus_next[3:0] | RS_BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= '0;
      nib       <= 1'b0;
      phase     <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (last_res) begin
          byte_idx <= '0;
          nib      <= 1'b0;
          phase    <= '0;
        end else if (phase == 2'd2) begin
          phase <= '0;
          nib   <= !nib;
          if (nib) begin
            byte_idx <= byte_idx + 2'd1;
          end
        end else begin
          phase <= phase + 2'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (head.nbytes == 2'd0) begin
        bus_byte   <= '0;
        byte_valid <= 1'b0;
        status     <= head.status;
      end else begin
        bus_byte   <= bus_next;
        byte_valid <= 1'b1;
        status     <= STATUS_OK;
      end
      last <= last_res;
    end
  end

`ifndef SYNTHESIS
  a_status_only_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last)
    else $error("status-only result not marked last");
  a_error_has_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> !byte_valid)
    else $error("error status on a bus byte result");
  a_counters_idle_between: assert property (@(posedge clk) disable iff (rst)
    pop |=> byte_idx == 2'd0 && !nib && phase == 2'd0)
    else $error("expansion counters not cleared after an operation");
`endif

endmodule

>>> verif/text_to_char_lcd_i2c_bytes_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the text to character LCD bus byte converter.
module text_to_char_lcd_i2c_bytes_tb;
  import lcdi_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned ITEMS_PER_PHASE = 28;
  localparam logic [6:0] ROW1_BASE = 7'h40;
  localparam logic [1:0] ROWS = 2'd2;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] char_code;
    logic [5:0] column;
    logic [1:0] row;
    logic       backlight_req;
  } text_item_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       is_last;
  } bus_result_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // char_code[7:0], column[13:8], line[15:14],
                               // backlight_req[16], zero[23:17]
  logic [2:0]  s_tuser = '0;   // func[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // bus_byte[7:0], status[9:8], zero[15:10]
  logic        m_tuser;        // byte_valid[0]
  logic        m_tlast;

  text_item_t  text_items[$];
  bus_result_t bus_bytes_due[$];
  idle_mode_t  idle_mode = IDLE_NONE;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count = 0;

  // Shadow copy of the display state.
  logic [5:0]  lcd_col = '0;
  logic        lcd_row = 1'b0;
  logic        lcd_backlight = 1'b1;

  text_to_char_lcd_i2c_bytes u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  function automatic void push_bus_byte(logic [7:0] b, logic valid, logic [1:0] status);
    bus_result_t r;
    r.bus_byte = b;
    r.byte_valid = valid;
    r.status = status;
    r.is_last = 1'b0;
    bus_bytes_due.push_back(r);
  endfunction

  // One nibble goes out plain, with enable high, and plain again.
  function automatic void push_nibble(logic [3:0] nib, logic rs);
    logic [7:0] b;
    b = {nib, (rs ? RS_BIT : 4'h0) | (lcd_backlight ? BL_BIT : 4'h0)};
    push_bus_byte(b, 1'b1, STATUS_OK);
    push_bus_byte(b | {4'h0, EN_BIT}, 1'b1, STATUS_OK);
    push_bus_byte(b, 1'b1, STATUS_OK);
  endfunction

  function automatic void push_lcd_byte(logic [7:0] v, logic rs);
    push_nibble(v[7:4], rs);
    push_nibble(v[3:0], rs);
  endfunction

  function automatic void issue_command(logic [7:0] cmd);
    push_lcd_byte(cmd, 1'b0);
    if (cmd == CMD_CLEAR || cmd == CMD_HOME) begin
      lcd_col = '0;
      lcd_row = 1'b0;
    end
  endfunction

  function automatic void write_char(logic [7:0] ch);
    push_lcd_byte(ch, 1'b1);
    lcd_col = lcd_col + 6'd1;
    if (lcd_col >= COL_LIMIT) begin
      lcd_col = '0;
      lcd_row = ~lcd_row;
    end
  endfunction

  function automatic void goto_cursor(logic [5:0] col, logic r);
    logic [6:0] addr;
    addr = (r ? ROW1_BASE : 7'h00) + {1'b0, col};
    lcd_col = col;
    lcd_row = r;
    issue_command(CMD_SET_DDRAM | {1'b0, addr});
  endfunction

  function automatic void predict_bus_bytes(text_item_t it);
    int unsigned first;
    logic [1:0]  status;
    first = bus_bytes_due.size();
    status = STATUS_OK;
    case (it.func)
      FUNC_CHAR: begin
        case (it.char_code)
          CH_NEWLINE: goto_cursor('0, ~lcd_row);
          CH_RETURN: goto_cursor('0, lcd_row);
          CH_FORMFEED: issue_command(CMD_CLEAR);
          CH_BACKSPACE: begin
            if (lcd_col != '0) begin
              goto_cursor(lcd_col - 6'd1, lcd_row);
              write_char(CH_SPACE);
              goto_cursor(lcd_col - 6'd1, lcd_row);
            end
          end
          default: begin
            if (it.char_code >= CH_SPACE && it.char_code <= CH_PRINT_MAX) begin
              write_char(it.char_code);
            end
          end
        endcase
      end
      FUNC_CLEAR: issue_command(CMD_CLEAR);
      FUNC_HOME: issue_command(CMD_HOME);
      FUNC_SET_CURSOR: begin
        if (it.column >= COL_LIMIT || it.row >= ROWS) begin
          status = STATUS_RANGE;
        end else begin
          goto_cursor(it.column, it.row[0]);
        end
      end
      FUNC_BACKLIGHT: lcd_backlight = it.backlight_req;
      default: status = STATUS_UNKNOWN;
    endcase
    if (bus_bytes_due.size() == first) begin
      push_bus_byte(8'h00, 1'b0, status);
    end
    bus_bytes_due[bus_bytes_due.size() - 1].is_last = 1'b1;
  endfunction

  function automatic text_item_t make_item(logic [2:0] func, logic [7:0] ch, logic [5:0] col,
                                           logic [1:0] r, logic bl);
    text_item_t it;
    it.func = func;
    it.char_code = ch;
    it.column = col;
    it.row = r;
    it.backlight_req = bl;
    return it;
  endfunction

  // Mostly printable text with control characters mixed in, so that the cursor
  // wraps and backspace finds a nonzero column; the rest are commands and noise.
  function automatic text_item_t random_item();
    text_item_t  it;
    int unsigned pick;
    logic [7:0]  specials[4];
    specials[0] = CH_NEWLINE;
    specials[1] = CH_RETURN;
    specials[2] = CH_FORMFEED;
    specials[3] = CH_BACKSPACE;
    it = make_item(3'($urandom_range(7)), 8'($urandom), 6'($urandom), 2'($urandom),
                   1'($urandom));
    pick = $urandom_range(99);
    if (pick < 50) begin
      it.func = FUNC_CHAR;
      it.char_code = 8'($urandom_range(CH_PRINT_MAX, CH_SPACE));
    end else if (pick < 65) begin
      it.func = FUNC_CHAR;
      it.char_code = specials[$urandom_range(3)];
    end else if (pick < 73) begin
      it.func = FUNC_CHAR;
    end else if (pick < 78) begin
      it.func = ($urandom_range(1) != 0) ? FUNC_CLEAR : FUNC_HOME;
    end else if (pick < 88) begin
      it.func = FUNC_SET_CURSOR;
      if ($urandom_range(4) != 0) begin
        it.column = 6'($urandom_range(COLUMNS - 1));
        it.row = 2'($urandom_range(1));
      end
    end else if (pick < 95) begin
      it.func = FUNC_BACKLIGHT;
    end else begin
      it.func = 3'($urandom_range(7, 5));
    end
    return it;
  endfunction

  function automatic logic idle_now(logic on_sender);
    idle_mode_t heavy;
    heavy = on_sender ? IDLE_SENDER : IDLE_RECEIVER;
    if (idle_mode == heavy) return $urandom_range(99) < 80;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 9;
    return 1'b0;
  endfunction

  always @(negedge clk) begin : drive_ports
    text_item_t it;
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (text_items.size() != 0 && !idle_now(1'b1)) begin
          it = text_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {7'b0, it.backlight_req, it.row, it.column, it.char_code};
          s_tuser <= it.func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= !idle_now(1'b0);
    end
  end

  always @(posedge clk) begin : watch_ports
    bus_result_t due;
    in_taken = s_tvalid && s_tready && !rst;
    out_taken = m_tvalid && m_tready && !rst;
    if (in_taken) begin
      predict_bus_bytes(make_item(s_tuser, s_tdata[7:0], s_tdata[13:8], s_tdata[15:14],
                                  s_tdata[16]));
    end
    if (out_taken) begin
      if (bus_bytes_due.size() == 0) begin
        $error("unexpected output transaction: bus_byte %h status %0d byte_valid %0d",
               m_tdata[7:0], m_tdata[9:8], m_tuser);
        fail_count++;
      end else begin
        due = bus_bytes_due.pop_front();
        if (m_tdata[7:0] !== due.bus_byte) begin
          $error("bus_byte: expected %h, actual %h", due.bus_byte, m_tdata[7:0]);
          fail_count++;
        end
        if (m_tuser !== due.byte_valid) begin
          $error("byte_valid: expected %0d, actual %0d", due.byte_valid, m_tuser);
          fail_count++;
        end
        if (m_tdata[9:8] !== due.status) begin
          $error("status: expected %0d, actual %0d", due.status, m_tdata[9:8]);
          fail_count++;
        end
        if (m_tlast !== due.is_last) begin
          $error("last: expected %0d, actual %0d", due.is_last, m_tlast);
          fail_count++;
        end
      end
    end
    idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
  end

  initial begin : stall_watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL text_to_char_lcd_i2c_bytes");
    $finish;
  end

  initial begin : run_phases
    idle_mode_t modes[4];
    modes[0] = IDLE_NONE;
    modes[1] = IDLE_SENDER;
    modes[2] = IDLE_RECEIVER;
    modes[3] = IDLE_BOTH;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: character extremes, control characters and every command.
    text_items.push_back(make_item(FUNC_CHAR, 8'h41, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_CHAR, CH_SPACE, 6'h3F, 2'd3, 1'b1));
    text_items.push_back(make_item(FUNC_CHAR, CH_PRINT_MAX, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_CHAR, 8'h1F, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_CHAR, 8'h80, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_CHAR, 8'hFF, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_CHAR, CH_BACKSPACE, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_CHAR, CH_NEWLINE, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_CHAR, 8'h7A, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_CHAR, CH_RETURN, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_CHAR, CH_NEWLINE, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_CHAR, CH_FORMFEED, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_CHAR, CH_BACKSPACE, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_SET_CURSOR, 8'h00, 6'd15, 2'd1, 1'b0));
    text_items.push_back(make_item(FUNC_CHAR, 8'h30, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_SET_CURSOR, 8'h00, 6'd16, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_SET_CURSOR, 8'h00, 6'd0, 2'd2, 1'b0));
    text_items.push_back(make_item(FUNC_SET_CURSOR, 8'hFF, 6'h3F, 2'd3, 1'b1));
    text_items.push_back(make_item(FUNC_SET_CURSOR, 8'h00, 6'd0, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_BACKLIGHT, 8'h00, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_CHAR, 8'h55, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_BACKLIGHT, 8'h00, 6'h00, 2'd0, 1'b1));
    text_items.push_back(make_item(FUNC_CLEAR, 8'h00, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(FUNC_HOME, 8'h00, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(3'd5, 8'h00, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(3'd6, 8'h00, 6'h00, 2'd0, 1'b0));
    text_items.push_back(make_item(3'd7, 8'hFF, 6'h3F, 2'd3, 1'b1));

    foreach (modes[p]) begin
      idle_mode = modes[p];
      repeat (ITEMS_PER_PHASE) text_items.push_back(random_item());
      while (text_items.size() != 0 || s_tvalid || bus_bytes_due.size() != 0) begin
        @(posedge clk);
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && bus_bytes_due.size() == 0) begin
      $display("PASS text_to_char_lcd_i2c_bytes");
    end else begin
      $display("FAIL text_to_char_lcd_i2c_bytes");
    end
    $finish;
  end

endmodule

>>> text_to_char_lcd_i2c_bytes.f
design/lcdi_pkg.sv
design/lcdi_front.sv
design/lcdi_queue.sv
design/lcdi_back.sv
design/text_to_char_lcd_i2c_bytes.sv
verif/text_to_char_lcd_i2c_bytes_tb.sv
